@@ src/bblc_pkg.sv @@
`default_nettype none

package bblc_pkg;

   // Defaults of the top-level parameters.
   localparam int unsigned FULL_SCALE_DEF = 1024;
   localparam int unsigned MAX_WIDTH_DEF  = 8192;

   localparam int unsigned PIXEL_W     = 16;
   localparam int unsigned CLAMP_W     = 10;
   localparam int unsigned WIDTH_REG_W = 14;
   localparam int unsigned CSR_DATA_W  = 14;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned NUM_CH      = 4;

   // Gains carry this many fraction bits.
   localparam int unsigned GAIN_FRAC = 10;

   localparam int unsigned CLAMP_RST = 64;
   localparam int unsigned WIDTH_RST = 1920;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BAYER_PATTERN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_CLAMP        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_RED_CLAMP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_BLUE_CLAMP = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_CLAMP       = 3'd5;

   typedef enum logic [1:0] {
      CH_R  = 2'd0,
      CH_GR = 2'd1,
      CH_GB = 2'd2,
      CH_B  = 2'd3
   } channel_type;

   typedef enum logic [1:0] {
      PAT_RGGB = 2'd0,
      PAT_BGGR = 2'd1,
      PAT_GBRG = 2'd2,
      PAT_GRBG = 2'd3
   } pattern_type;

   // Color of a site from the filter layout and the row and column parities.
   function automatic channel_type bayer_channel(input pattern_type pattern,
                                                 input logic odd_row,
                                                 input logic odd_col);
      channel_type even_a;
      channel_type even_b;
      channel_type odd_a;
      channel_type odd_b;
      case (pattern)
         PAT_RGGB: begin
            even_a = CH_R;  even_b = CH_GR; odd_a = CH_GB; odd_b = CH_B;
         end
         PAT_BGGR: begin
            even_a = CH_B;  even_b = CH_GB; odd_a = CH_GR; odd_b = CH_R;
         end
         PAT_GBRG: begin
            even_a = CH_GB; even_b = CH_B;  odd_a = CH_R;  odd_b = CH_GR;
         end
         default: begin
            even_a = CH_GR; even_b = CH_R;  odd_a = CH_B;  odd_b = CH_GB;
         end
      endcase
      if (odd_row) begin
         return odd_col ? odd_b : odd_a;
      end
      return odd_col ? even_b : even_a;
   endfunction

endpackage

`default_nettype wire

@@ src/bblc_gain_lane.sv @@
`default_nettype none

// One color channel: its black clamp and its gain, with a bit-serial
// restoring divider that rebuilds the gain one quotient bit per cycle.
module bblc_gain_lane #(
   parameter int unsigned FULL_SCALE = bblc_pkg::FULL_SCALE_DEF,
   localparam int unsigned GAIN_W = $clog2((FULL_SCALE << bblc_pkg::GAIN_FRAC) + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [bblc_pkg::CLAMP_W-1:0] wr_clamp,
   output logic      [bblc_pkg::CLAMP_W-1:0] clamp,
   output logic      [GAIN_W-1:0]            gain,
   output logic                              busy
);
   import bblc_pkg::*;

   localparam int unsigned DIV_W   = $clog2(FULL_SCALE + 1);
   localparam int unsigned CMP_W   = DIV_W + 1;
   localparam int unsigned CNT_W   = $clog2(GAIN_W);
   localparam int unsigned RST_DIV = (FULL_SCALE > CLAMP_RST) ? FULL_SCALE - CLAMP_RST : 1;
   localparam int unsigned RST_GAIN = (FULL_SCALE << GAIN_FRAC) / RST_DIV;

   localparam logic [GAIN_W-1:0] NUMERATOR = GAIN_W'(FULL_SCALE << GAIN_FRAC);
   localparam logic [CMP_W-1:0]  FS_V      = CMP_W'(FULL_SCALE);

   logic [CLAMP_W-1:0] clamp_ff, clamp_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;

   logic [CMP_W-1:0] clamp_x;
   logic [DIV_W-1:0] div_load;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   trial_sub;
   logic             fits;

   always_comb begin
      clamp_x  = CMP_W'(wr_clamp);
      // A clamp at or above full scale divides by one.
      div_load = (clamp_x < FS_V) ? DIV_W'(FS_V - clamp_x) : DIV_W'(1);

      trial     = {rem_ff, NUMERATOR[cnt_ff]};
      trial_sub = trial - {1'b0, div_ff};
      fits      = (trial >= {1'b0, div_ff});

      clamp_in = clamp_ff;
      gain_in  = gain_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (wr_en) begin
         // A new write restarts the division, even in the middle of one.
         clamp_in = wr_clamp;
         div_in   = div_load;
         rem_in   = '0;
         cnt_in   = CNT_W'(GAIN_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
         gain_in = {gain_ff[GAIN_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= CLAMP_W'(CLAMP_RST);
         gain_ff  <= GAIN_W'(RST_GAIN);
         busy_ff  <= 1'b0;
      end else begin
         clamp_ff <= clamp_in;
         gain_ff  <= gain_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign clamp = clamp_ff;
   assign gain  = gain_ff;
   assign busy  = busy_ff;

endmodule

`default_nettype wire

@@ src/bblc_raster_pos.sv @@
`default_nettype none

// Raster position and color site: column counter, row parity, row width
// and filter layout registers.
module bblc_raster_pos #(
   parameter int unsigned MAX_WIDTH = bblc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            width_we,
   input  wire logic                            pattern_we,
   input  wire logic [bblc_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                            frame_start,
   input  wire logic                            advance,
   output bblc_pkg::channel_type                channel
);
   import bblc_pkg::*;

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned EW    = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

   localparam logic [EW-1:0] MAX_V = EW'(MAX_WIDTH);
   localparam logic [EW-1:0] MIN_V = EW'(2);

   logic [WIDTH_REG_W-1:0] width_ff, width_in;
   pattern_type            pattern_ff, pattern_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic                   odd_ff, odd_in;

   logic [EW-1:0]    eff_width;
   logic [EW-1:0]    col_inc;
   logic [COL_W-1:0] col_cur;
   logic             odd_cur;
   logic             wrap;

   always_comb begin
      eff_width = EW'(width_ff);
      if (eff_width < MIN_V) begin
         eff_width = MIN_V;
      end
      if (eff_width > MAX_V) begin
         eff_width = MAX_V;
      end

      // A frame start puts this request at column zero of an even row.
      col_cur = frame_start ? '0 : col_ff;
      odd_cur = frame_start ? 1'b0 : odd_ff;
      channel = bayer_channel(pattern_ff, odd_cur, col_cur[0]);

      col_inc = EW'(col_cur) + 1'b1;
      wrap    = (col_inc >= eff_width);

      width_in   = width_we ? csr_data[WIDTH_REG_W-1:0] : width_ff;
      pattern_in = pattern_we ? pattern_type'(csr_data[1:0]) : pattern_ff;
      col_in     = col_ff;
      odd_in     = odd_ff;
      if (advance) begin
         col_in = wrap ? '0 : col_inc[COL_W-1:0];
         odd_in = wrap ? ~odd_cur : odd_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_REG_W'(WIDTH_RST);
         pattern_ff <= PAT_RGGB;
         col_ff     <= '0;
         odd_ff     <= 1'b0;
      end else begin
         width_ff   <= width_in;
         pattern_ff <= pattern_in;
         col_ff     <= col_in;
         odd_ff     <= odd_in;
      end
   end

endmodule

`default_nettype wire

@@ src/bblc_pixel_pipe.sv @@
`default_nettype none

// Two-stage pixel path: clamp subtraction into the input register, then
// gain multiply, shift and saturation into the output register.
module bblc_pixel_pipe #(
   parameter int unsigned FULL_SCALE = bblc_pkg::FULL_SCALE_DEF,
   localparam int unsigned GAIN_W = $clog2((FULL_SCALE << bblc_pkg::GAIN_FRAC) + 1)
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              req_tvalid,
   output logic                                                   req_tready,
   input  wire logic [bblc_pkg::PIXEL_W-1:0]                      req_pixel,
   input  wire bblc_pkg::channel_type                             req_channel,
   input  wire logic [bblc_pkg::NUM_CH-1:0][bblc_pkg::CLAMP_W-1:0] clamps,
   input  wire logic [bblc_pkg::NUM_CH-1:0][GAIN_W-1:0]           gains,
   input  wire logic                                              gain_busy,
   output logic                                                   req_accept,
   output logic                                                   rsp_tvalid,
   input  wire logic                                              rsp_tready,
   output logic      [bblc_pkg::PIXEL_W-1:0]                      rsp_pixel,
   output bblc_pkg::channel_type                                  rsp_channel
);
   import bblc_pkg::*;

   localparam int unsigned PROD_W = PIXEL_W + GAIN_W;
   localparam int unsigned SCL_W  = PROD_W - GAIN_FRAC;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] diff_ff, diff_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   channel_type        s1_ch_ff;

   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff, out_pixel_in;
   channel_type        out_ch_ff;

   logic               out_free;
   logic               s1_free;
   logic               s1_move;
   logic               accept;
   logic [PIXEL_W-1:0] clamp_x;
   logic [PROD_W-1:0]  product;
   logic [SCL_W-1:0]   scaled;

   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      s1_free    = !s1_valid_ff || out_free;
      s1_move    = s1_valid_ff && out_free;
      // Gains being rebuilt after a clamp write hold off new requests.
      req_tready = s1_free && !gain_busy;
      accept     = req_tvalid && req_tready;

      clamp_x = PIXEL_W'(clamps[req_channel]);
      diff_in = (req_pixel > clamp_x) ? req_pixel - clamp_x : '0;
      gain_in = gains[req_channel];

      product      = PROD_W'(diff_ff) * PROD_W'(gain_ff);
      scaled       = product[PROD_W-1:GAIN_FRAC];
      out_pixel_in = (|scaled[SCL_W-1:PIXEL_W]) ? '1 : scaled[PIXEL_W-1:0];

      s1_valid_in  = s1_free ? accept : s1_valid_ff;
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         diff_ff  <= diff_in;
         gain_ff  <= gain_in;
         s1_ch_ff <= req_channel;
      end
      if (s1_move) begin
         out_pixel_ff <= out_pixel_in;
         out_ch_ff    <= s1_ch_ff;
      end
   end

   assign req_accept  = accept;
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_pixel   = out_pixel_ff;
   assign rsp_channel = out_ch_ff;

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> !gain_busy)
      else $error("request accepted while a gain is being rebuilt");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request did not reach the input register");

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while both stages are full and stalled");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> out_valid_ff)
      else $error("input register content lost on its way to the output");

endmodule

`default_nettype wire

@@ src/bayer_black_level_correction_unit.sv @@
`default_nettype none

// Bayer black level correction.
// Requests on req_* carry one raw pixel in raster order, with tuser marking
// the first pixel of a frame. Responses on rsp_* carry the corrected pixel and
// its color channel (0 R, 1 Gr, 2 Gb, 3 B), one response per request, in order.
// Each pixel has its channel's clamp subtracted (floored at zero), is scaled by
// FULL_SCALE*1024/(FULL_SCALE-clamp), shifted right by 10 and saturated.
// rsp_tvalid is driven by the output register, which a request reaches through
// the input register; while rsp_tready is high and no gain is being rebuilt, one
// request is taken every cycle. Writing a clamp through csr_* rebuilds that
// channel's gain in a bit-serial divider: req_tready stays low until every
// divider has finished after the last clamp write.
// Reset sets width 1920, RGGB layout, all clamps 64 with their gains, and
// empties both pipeline stages; the block is ready right after reset.
// When rsp_tready is low with a response pending, the output register holds,
// an empty input register still takes one more request, and then req_tready drops.
module bayer_black_level_correction_unit #(
   parameter int unsigned FULL_SCALE = bblc_pkg::FULL_SCALE_DEF,
   parameter int unsigned MAX_WIDTH  = bblc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request: tdata = pixel_in[15:0]; tuser = frame_start.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [15:0]                      req_tdata,
   input  wire logic                             req_tuser,
   // Response: tdata = pixel_out[15:0]; tuser = channel[1:0].
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [15:0]                           rsp_tdata,
   output logic [1:0]                            rsp_tuser,
   input  wire logic                             csr_we,
   input  wire logic [bblc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bblc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bblc_pkg::*;

   localparam int unsigned GAIN_W = $clog2((FULL_SCALE << GAIN_FRAC) + 1);

   logic [NUM_CH-1:0][CLAMP_W-1:0] clamps;
   logic [NUM_CH-1:0][GAIN_W-1:0]  gains;
   logic [NUM_CH-1:0]              lane_busy;
   logic                           width_we;
   logic                           pattern_we;
   logic                           req_accept;
   channel_type                    req_channel;
   channel_type                    rsp_channel;

   assign width_we   = csr_we && (csr_index == REG_IMAGE_WIDTH);
   assign pattern_we = csr_we && (csr_index == REG_BAYER_PATTERN);

   for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
      logic lane_we;
      assign lane_we = csr_we && (csr_index == CSR_INDEX_W'(REG_RED_CLAMP + k));

      bblc_gain_lane #(
         .FULL_SCALE (FULL_SCALE)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (lane_we),
         .wr_clamp (csr_wdata[CLAMP_W-1:0]),
         .clamp    (clamps[k]),
         .gain     (gains[k]),
         .busy     (lane_busy[k])
      );
   end

   bblc_raster_pos #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .width_we    (width_we),
      .pattern_we  (pattern_we),
      .csr_data    (csr_wdata),
      .frame_start (req_tuser),
      .advance     (req_accept),
      .channel     (req_channel)
   );

   bblc_pixel_pipe #(
      .FULL_SCALE (FULL_SCALE)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_pixel   (req_tdata),
      .req_channel (req_channel),
      .clamps      (clamps),
      .gains       (gains),
      .gain_busy   (|lane_busy),
      .req_accept  (req_accept),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_pixel   (rsp_tdata),
      .rsp_channel (rsp_channel)
   );

   assign rsp_tuser = rsp_channel;

endmodule

`default_nettype wire
